// File: rtl/ipf_pkg.sv
// shared types and constants of the iso 14443-a parity framer
package ipf_pkg;

   localparam int DATA_W      = 8;
   localparam int COUNT_W     = 4;
   localparam int TOTAL_W     = 12;
   localparam int BYTE_BITS   = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] FULL_BYTE_COUNT = COUNT_W'(BYTE_BITS);

   // chunk kinds
   typedef enum logic {
      KIND_LEAD = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

   // one result beat
   typedef struct packed {
      logic [DATA_W-1:0]  out_byte;
      logic [COUNT_W-1:0] valid_bits;
      logic               frame_end;
      logic [TOTAL_W-1:0] total_bits;
   } rsp_item_type;

   // results caused by one chunk, one or two of them
   typedef struct packed {
      rsp_item_type res0;
      rsp_item_type res1;
      logic         two;
   } desc_type;

   // front to queue
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   // queue to back
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } head_type;

endpackage

// File: rtl/ipf_if.sv
// chunk and result channel interfaces
interface ipf_req_if;
   import ipf_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [DATA_W-1:0]   data;
   logic [COUNT_W-1:0]  bit_count;
   logic                last;

   modport source (output valid, kind, data, bit_count, last, input ready);
   modport sink   (input valid, kind, data, bit_count, last, output ready);
endinterface

interface ipf_rsp_if;
   import ipf_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   out_byte;
   logic [COUNT_W-1:0]  valid_bits;
   logic                frame_end;
   logic [TOTAL_W-1:0]  total_bits;

   modport source (output valid, out_byte, valid_bits, frame_end, total_bits, input ready);
   modport sink   (input valid, out_byte, valid_bits, frame_end, total_bits, output ready);
endinterface

// File: rtl/ipf_front.sv
// front end: accepts chunks, packs bits, works out the result beats
module ipf_front (
   input  logic                clock,
   input  logic                reset,
   ipf_req_if.sink             req_chan,
   input  logic                queue_full,
   output ipf_pkg::push_type   push
);
   import ipf_pkg::*;

   logic [DATA_W-1:0]  pack_byte_ff, pack_byte_in;
   logic [2:0]         pack_fill_ff, pack_fill_in;
   logic [TOTAL_W-1:0] bit_total_ff, bit_total_in;

   logic [COUNT_W-1:0] count;
   logic               has_data;
   logic               extra;
   logic               extra_bit;
   logic [COUNT_W-1:0] n_bits;
   logic [DATA_W:0]    data9;
   logic [DATA_W:0]    seq;
   logic [15:0]        rev16;
   logic [15:0]        word;
   logic [4:0]         sum;
   logic [1:0]         full_cnt;
   logic [2:0]         new_fill;
   logic [DATA_W-1:0]  rem_byte;
   logic [TOTAL_W-1:0] t0, t1, tn;
   rsp_item_type       full0, full1, part, empty_end;
   desc_type           desc;
   logic               has_res;
   logic               accept;

   // saturating add of up to sixteen bits
   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [4:0] k);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W+1)'(k);
      return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   // chunk length and the bit that follows it
   always_comb begin
      count     = (req_chan.bit_count > FULL_BYTE_COUNT) ? FULL_BYTE_COUNT
                                                        : req_chan.bit_count;
      has_data  = (count != '0);
      extra     = has_data && ((req_chan.kind == KIND_LEAD) || (count == FULL_BYTE_COUNT));
      extra_bit = (req_chan.kind == KIND_DATA) ? ~^req_chan.data : 1'b0;
      n_bits    = count + COUNT_W'(extra);
      data9     = {1'b0, req_chan.data};
   end

   // bit sequence in send order, then placed after the bits already packed
   always_comb begin
      seq   = '0;
      rev16 = '0;
      for (int i = 0; i <= DATA_W; i++) begin
         if (COUNT_W'(i) < count)
            seq[i] = data9[i];
         else if ((COUNT_W'(i) == count) && extra)
            seq[i] = extra_bit;
      end
      for (int i = 0; i <= DATA_W; i++) begin
         rev16[15-i] = seq[i];
      end
      word = {pack_byte_ff, 8'h00} | (rev16 >> pack_fill_ff);
   end

   // completed bytes, remainder and running totals
   always_comb begin
      sum      = {2'b00, pack_fill_ff} + {1'b0, n_bits};
      full_cnt = sum[4] ? 2'd2 : (sum[3] ? 2'd1 : 2'd0);
      new_fill = sum[2:0];
      unique case (full_cnt)
         2'd0:    rem_byte = word[15:8];
         2'd1:    rem_byte = word[7:0];
         default: rem_byte = '0;
      endcase
      t0 = sat_add(bit_total_ff, 5'd8 - {2'b00, pack_fill_ff});
      t1 = sat_add(bit_total_ff, 5'd16 - {2'b00, pack_fill_ff});
      tn = sat_add(bit_total_ff, {1'b0, n_bits});

      full0     = '{out_byte: word[15:8], valid_bits: FULL_BYTE_COUNT,
                    frame_end: 1'b0, total_bits: t0};
      full1     = '{out_byte: word[7:0], valid_bits: FULL_BYTE_COUNT,
                    frame_end: 1'b0, total_bits: t1};
      part      = '{out_byte: rem_byte, valid_bits: {1'b0, new_fill},
                    frame_end: 1'b1, total_bits: tn};
      empty_end = '{out_byte: '0, valid_bits: '0,
                    frame_end: 1'b1, total_bits: bit_total_ff};
   end

   // choose the beats of this chunk
   always_comb begin
      desc.res0 = full0;
      desc.res1 = full1;
      desc.two  = (full_cnt == 2'd2);
      has_res   = (full_cnt != 2'd0);
      if (req_chan.last) begin
         has_res = 1'b1;
         if (new_fill != '0) begin
            if (full_cnt == 2'd0) begin
               desc.res0 = part;
               desc.two  = 1'b0;
            end else begin
               desc.res1 = part;
               desc.two  = 1'b1;
            end
         end else if (full_cnt == 2'd1) begin
            desc.res0.frame_end = 1'b1;
         end else if (full_cnt == 2'd2) begin
            desc.res1.frame_end = 1'b1;
         end else begin
            desc.res0 = empty_end;
            desc.two  = 1'b0;
         end
      end
      push.valid = accept && has_res;
      push.desc  = desc;
   end

   // packing state for the next chunk
   always_comb begin
      pack_byte_in = pack_byte_ff;
      pack_fill_in = pack_fill_ff;
      bit_total_in = bit_total_ff;
      if (accept) begin
         if (req_chan.last) begin
            pack_byte_in = '0;
            pack_fill_in = '0;
            bit_total_in = '0;
         end else begin
            pack_byte_in = rem_byte;
            pack_fill_in = new_fill;
            bit_total_in = tn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_byte_ff <= '0;
         pack_fill_ff <= '0;
         bit_total_ff <= '0;
      end else begin
         pack_byte_ff <= pack_byte_in;
         pack_fill_ff <= pack_fill_in;
         bit_total_ff <= bit_total_in;
      end
   end

endmodule

// File: rtl/ipf_queue.sv
// short queue of result descriptors between front and back
module ipf_queue #(
   parameter int QUEUE_DEPTH = ipf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ipf_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output ipf_pkg::head_type  head
);
   import ipf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   desc_type          slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.desc  = slots[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!do_push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // descriptor storage
   always_ff @(posedge clock) begin
      if (do_push)
         slots[wr_ptr_ff] <= push.desc;
   end

endmodule

// File: rtl/ipf_back.sv
// back end: steps through the beats of each descriptor into the output register
module ipf_back (
   input  logic               clock,
   input  logic               reset,
   input  ipf_pkg::head_type  head,
   output logic               pop,
   ipf_rsp_if.source          rsp_chan
);
   import ipf_pkg::*;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic          sel_ff, sel_in;
   logic          load;
   logic          last_beat;

   assign load      = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign last_beat = sel_ff || !head.desc.two;
   assign pop       = load && last_beat;

   // next beat and output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      sel_in       = sel_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = sel_ff ? head.desc.res1 : head.desc.res0;
         sel_in       = !last_beat;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_item_ff.out_byte;
   assign rsp_chan.valid_bits = rsp_item_ff.valid_bits;
   assign rsp_chan.frame_end  = rsp_item_ff.frame_end;
   assign rsp_chan.total_bits = rsp_item_ff.total_bits;

endmodule

// File: rtl/iso14443a_parity_framer.sv
// top level of the iso 14443-a parity framer
// Transmit-side bit framer. Chunks of 0 to 8 bits arrive on req_chan, LSB sent
// first; full data chunks get an odd parity bit, leading chunks a zero bit.
// Frame bits are packed MSB first and each finished byte leaves on rsp_chan as
// one beat with its running bit total (saturating at 4095). A chunk with last
// set flushes the partial byte and marks the final beat with frame_end.
// Both channels use valid/ready; a beat moves when both are high.
// A chunk's first result beat passes through the queue and then the output
// register before the receiver can take it.
// Throughput: the front takes one chunk per cycle while the queue is not full;
// the back sends one result beat per cycle while the receiver is ready, so a
// chunk that completes two bytes gives two beats. The descriptor queue
// (QUEUE_DEPTH entries) lets the front keep taking chunks while the receiver
// stalls; req_chan.ready drops only when the queue is full. A stalled output
// beat holds until taken. Reset clears the packing state, the queue and the
// output valid; no frame is in progress afterwards.
module iso14443a_parity_framer #(
   parameter int QUEUE_DEPTH = ipf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ipf_req_if.sink    req_chan,
   ipf_rsp_if.source  rsp_chan
);
   import ipf_pkg::*;

   push_type  push;
   head_type  head;
   logic      queue_full;
   logic      pop;

   ipf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   ipf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   ipf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: sim/parity_frame_checker.sv
// scoreboard for the parity framer: predicts result beats from chunk beats and compares
`timescale 1ns / 1ps

module parity_frame_checker
   import ipf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ipf_req_if   req_mon,
   ipf_rsp_if   rsp_mon,
   output int   pending_beats,
   output int   mismatch_count
);

   // shadow of the framer's packing state
   logic [DATA_W-1:0]  shadow_byte;
   int unsigned        shadow_fill;
   logic [TOTAL_W-1:0] shadow_total;

   rsp_item_type expected_beats[$];
   rsp_item_type want;
   int           beats_from_chunk;
   int           errors;

   // place one frame bit, emit the byte once it is full
   function automatic void shift_in_bit(input logic frame_bit);
      rsp_item_type beat;
      shadow_byte[BYTE_BITS - 1 - shadow_fill] = frame_bit;
      if (shadow_total != TOTAL_MAX)
         shadow_total = shadow_total + 1'b1;
      shadow_fill++;
      if (shadow_fill == BYTE_BITS) begin
         beat.out_byte   = shadow_byte;
         beat.valid_bits = FULL_BYTE_COUNT;
         beat.frame_end  = 1'b0;
         beat.total_bits = shadow_total;
         expected_beats.push_back(beat);
         beats_from_chunk++;
         shadow_byte = '0;
         shadow_fill = 0;
      end
   endfunction

   // expected beats of one accepted chunk
   function automatic void frame_chunk(input kind_type kind, input logic [DATA_W-1:0] data,
                                       input logic [COUNT_W-1:0] count, input logic last);
      int unsigned  n;
      rsp_item_type beat;
      n = (count > BYTE_BITS) ? BYTE_BITS : count;
      beats_from_chunk = 0;
      for (int i = 0; i < n; i++)
         shift_in_bit(data[i]);
      // zero bit after a leading chunk, odd parity after a full data chunk
      if (n > 0) begin
         if (kind == KIND_LEAD)
            shift_in_bit(1'b0);
         else if (n == BYTE_BITS)
            shift_in_bit(~^data);
      end
      // flush at the end of the frame
      if (last) begin
         if (shadow_fill > 0) begin
            beat.out_byte   = shadow_byte;
            beat.valid_bits = COUNT_W'(shadow_fill);
            beat.frame_end  = 1'b1;
            beat.total_bits = shadow_total;
            expected_beats.push_back(beat);
         end else if (beats_from_chunk > 0) begin
            expected_beats[expected_beats.size() - 1].frame_end = 1'b1;
         end else begin
            beat.out_byte   = '0;
            beat.valid_bits = '0;
            beat.frame_end  = 1'b1;
            beat.total_bits = shadow_total;
            expected_beats.push_back(beat);
         end
         shadow_byte  = '0;
         shadow_fill  = 0;
         shadow_total = '0;
      end
   endfunction

   // watch both channels, compare before predicting
   always @(posedge clock) begin
      if (reset) begin
         shadow_byte  = '0;
         shadow_fill  = 0;
         shadow_total = '0;
         expected_beats.delete();
         errors = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: out_byte %0h valid_bits %0d",
                      rsp_mon.out_byte, rsp_mon.valid_bits);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_mon.out_byte !== want.out_byte) begin
                  $error("out_byte expected %0h actual %0h", want.out_byte, rsp_mon.out_byte);
                  errors++;
               end
               if (rsp_mon.valid_bits !== want.valid_bits) begin
                  $error("valid_bits expected %0d actual %0d",
                         want.valid_bits, rsp_mon.valid_bits);
                  errors++;
               end
               if (rsp_mon.frame_end !== want.frame_end) begin
                  $error("frame_end expected %0b actual %0b", want.frame_end, rsp_mon.frame_end);
                  errors++;
               end
               if (rsp_mon.total_bits !== want.total_bits) begin
                  $error("total_bits expected %0d actual %0d",
                         want.total_bits, rsp_mon.total_bits);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            frame_chunk(kind_type'(req_mon.kind), req_mon.data, req_mon.bit_count,
                        req_mon.last);
      end
      pending_beats  <= expected_beats.size();
      mismatch_count <= errors;
   end

endmodule

// File: sim/iso14443a_parity_framer_test.sv
// top of the parity framer testbench: clock, reset, chunk stimulus, receiver and verdict
`timescale 1ns / 1ps

module iso14443a_parity_framer_test;
   import ipf_pkg::*;

   localparam int CHUNK_TARGET   = 900;
   localparam int LONG_FRAME_LEN = 460;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_LIMIT     = 4000;
   localparam int TAIL_CYCLES    = 20;

   logic clock = 1'b0;
   logic reset;

   ipf_req_if req_chan ();
   ipf_rsp_if rsp_chan ();

   int pending_beats;
   int mismatch_count;
   int chunks_sent;
   int chunks_accepted;
   int idle_cycles;
   bit burst_mode;

   iso14443a_parity_framer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   parity_frame_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .pending_beats  (pending_beats),
      .mismatch_count (mismatch_count)
   );

   always #2 clock = ~clock;

   // gap length: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // accepted chunk count and watchdog on handshake activity
   always @(posedge clock) begin
      if (reset) begin
         chunks_accepted <= 0;
         idle_cycles = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            chunks_accepted <= chunks_accepted + 1;
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall_left;
      int quiet_left;
      bit quiet;
      bit hold_done;
      stall_left = 0;
      quiet_left = 0;
      quiet      = 1'b0;
      hold_done  = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_done && chunks_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (quiet_left == 0) begin
               quiet      = ($urandom_range(0, 3) == 0);
               quiet_left = $urandom_range(20, 120);
            end else begin
               quiet_left--;
            end
            if (stall_left > 0) begin
               rsp_chan.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_chan.ready <= 1'b1;
               if (!quiet && $urandom_range(0, 4) == 0)
                  stall_left = pick_gap();
            end
            @(posedge clock);
         end
      end
   end

   // offer one chunk beat and wait for its handshake
   task automatic send_chunk(input kind_type kind, input logic [DATA_W-1:0] data,
                             input logic [COUNT_W-1:0] count, input logic last);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.data      <= data;
      req_chan.bit_count <= count;
      req_chan.last      <= last;
      do
         @(posedge clock);
      while (!req_chan.ready);
      if (count != 0 || last)
         chunks_sent++;
   endtask

   // sender pause until every expected beat has arrived
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0)
         @(posedge clock);
   endtask

   // well-formed frame: optional leading chunk, full data chunks, optional partial tail
   task automatic send_good_frame(input int data_chunks);
      bit lead;
      bit tail;
      int n;
      lead = ($urandom_range(0, 2) == 0);
      tail = $urandom_range(0, 1);
      n    = data_chunks;
      if (!lead && !tail && n == 0)
         n = 1;
      burst_mode = ($urandom_range(0, 3) == 0);
      if (lead)
         send_chunk(KIND_LEAD, DATA_W'($urandom), COUNT_W'($urandom_range(1, 8)),
                    (n == 0 && !tail));
      for (int i = 0; i < n; i++)
         send_chunk(KIND_DATA, DATA_W'($urandom), FULL_BYTE_COUNT, (i == n - 1 && !tail));
      if (tail)
         send_chunk(KIND_DATA, DATA_W'($urandom), COUNT_W'($urandom_range(1, 7)), 1'b1);
   endtask

   // noise: any kind, any count including zero and above eight, rare last
   task automatic send_noise(input int chunks);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < chunks; i++)
         send_chunk(kind_type'($urandom_range(0, 1)), DATA_W'($urandom),
                    COUNT_W'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0));
   endtask

   // stimulus and verdict
   initial begin
      bit long_done;
      bit pause_done;
      long_done  = 1'b0;
      pause_done = 1'b0;
      chunks_sent = 0;
      burst_mode  = 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.kind      <= KIND_DATA;
      req_chan.data      <= '0;
      req_chan.bit_count <= '0;
      req_chan.last      <= 1'b0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single full chunks at the data extremes
      send_chunk(KIND_DATA, 8'h00, FULL_BYTE_COUNT, 1'b1);
      send_chunk(KIND_DATA, 8'hFF, FULL_BYTE_COUNT, 1'b1);
      // anticollision frame with a seven bit leading part
      send_chunk(KIND_LEAD, 8'h7F, 4'd7, 1'b0);
      send_chunk(KIND_DATA, 8'h93, FULL_BYTE_COUNT, 1'b0);
      send_chunk(KIND_DATA, 8'h20, FULL_BYTE_COUNT, 1'b1);
      // full leading chunk
      send_chunk(KIND_LEAD, 8'hA5, FULL_BYTE_COUNT, 1'b1);
      // last chunk with no bits, which gives an empty frame_end beat
      send_chunk(KIND_DATA, 8'h00, 4'd0, 1'b1);
      // empty leading chunk adds no zero bit
      send_chunk(KIND_LEAD, 8'hFF, 4'd0, 1'b0);
      send_chunk(KIND_DATA, 8'h01, 4'd1, 1'b1);
      // bit counts above eight
      send_chunk(KIND_DATA, 8'h5A, 4'd15, 1'b0);
      send_chunk(KIND_DATA, 8'hC3, 4'd9, 1'b1);
      // leading chunk in the middle of a frame
      send_chunk(KIND_DATA, 8'h12, FULL_BYTE_COUNT, 1'b0);
      send_chunk(KIND_LEAD, 8'h03, 4'd3, 1'b0);
      send_chunk(KIND_DATA, 8'h01, 4'd4, 1'b1);
      // last chunk ends exactly on a byte boundary
      send_chunk(KIND_LEAD, 8'h55, 4'd7, 1'b1);
      for (int i = 0; i < 8; i++)
         send_chunk(KIND_DATA, 8'h81 << i, FULL_BYTE_COUNT, (i == 7));
      wait_for_drain();

      // random frames, one long frame past the count limit, one mid-run pause
      while (chunks_sent < CHUNK_TARGET) begin
         if (!long_done && chunks_sent >= 350) begin
            long_done = 1'b1;
            send_good_frame(LONG_FRAME_LEN);
         end else if (!pause_done && chunks_sent >= 600) begin
            pause_done = 1'b1;
            wait_for_drain();
         end else if ($urandom_range(0, 4) == 0) begin
            send_noise($urandom_range(1, 4));
         end else begin
            send_good_frame($urandom_range(0, 6));
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ipf_pkg.sv
rtl/ipf_if.sv
rtl/ipf_front.sv
rtl/ipf_queue.sv
rtl/ipf_back.sv
rtl/iso14443a_parity_framer.sv
sim/parity_frame_checker.sv
sim/iso14443a_parity_framer_test.sv
